/* src/uefbs_pkg.sv */
`default_nettype none

package uefbs_pkg;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'b001,
    PH_CHUNK_HDR = 3'b010,
    PH_BODY      = 3'b100
  } phase_e;

  localparam logic [15:0] KIND_DATA  = 16'h0100;
  localparam logic [15:0] KIND_TONE  = 16'h0110;
  localparam logic [15:0] KIND_DUMMY = 16'h0111;
  localparam logic [15:0] KIND_GAP   = 16'h0112;

  localparam logic [7:0]  DUMMY_BYTE    = 8'h41;
  localparam logic [3:0]  CHUNK_HDR_LEN = 4'd6;

  localparam int unsigned RUN_W  = 17;
  localparam int unsigned SLOTS  = 22;
  localparam int unsigned SLOT_W = 5;

  localparam logic [SLOT_W-1:0] SLOT_PRE  = 5'd0;
  localparam logic [SLOT_W-1:0] SLOT_POST = 5'd21;

  // floor(ms * 125 / 104) == (ms * MS_RECIP) >> MS_SHIFT for every 16-bit ms
  localparam logic [23:0] MS_RECIP = 24'd10082462;
  localparam int unsigned MS_SHIFT = 23;

  typedef struct packed {
    logic [SLOTS-1:0]  levels;
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] idx_end;
    logic [15:0]       ms_a;
    logic [15:0]       ms_b;
  } job_t;

endpackage

`default_nettype wire

/* src/uefbs_parser.sv */
`default_nettype none

module uefbs_parser
  import uefbs_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 12
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       file_start_i,
  input  wire logic       take_i,
  output logic            job_valid_o,
  output job_t            job_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic [15:0] kind_q, kind_d;
  logic [31:0] rem_q, rem_d;
  logic [2:0]  bidx_q, bidx_d;
  logic [7:0]  dshift_q, dshift_d;
  logic [15:0] pre_q, pre_d;
  logic        job_valid_q;
  job_t        job_q, job_d;
  logic        produce;
  logic        skip;
  logic [15:0] ms_w;

  always_comb begin
    phase_d  = phase_q;
    hcnt_d   = hcnt_q;
    kind_d   = kind_q;
    rem_d    = rem_q;
    bidx_d   = bidx_q;
    dshift_d = dshift_q;
    pre_d    = pre_q;
    skip     = 1'b0;
    produce  = 1'b0;
    ms_w     = {data_byte_i, dshift_q};
    job_d    = '0;

    if (file_start_i) begin
      phase_d  = PH_HEADER;
      hcnt_d   = '0;
      kind_d   = '0;
      rem_d    = '0;
      bidx_d   = '0;
      dshift_d = '0;
      pre_d    = '0;
      ms_w     = {data_byte_i, 8'h00};
    end

    if (phase_d == PH_HEADER) begin
      if (hcnt_d < 4'(HEADER_BYTES)) begin
        hcnt_d = hcnt_d + 4'd1;
        skip   = 1'b1;
      end else begin
        phase_d = PH_CHUNK_HDR;
        hcnt_d  = '0;
      end
    end

    if (!skip && phase_d == PH_CHUNK_HDR) begin
      case (hcnt_d)
        4'd0:    kind_d = {8'h00, data_byte_i};
        4'd1:    kind_d[15:8] = data_byte_i;
        4'd2:    rem_d = {24'h000000, data_byte_i};
        4'd3:    rem_d[15:8] = data_byte_i;
        4'd4:    rem_d[23:16] = data_byte_i;
        default: rem_d[31:24] = data_byte_i;
      endcase
      hcnt_d = hcnt_d + 4'd1;
      if (hcnt_d >= CHUNK_HDR_LEN) begin
        hcnt_d  = '0;
        bidx_d  = '0;
        phase_d = (rem_d == 32'd0) ? PH_CHUNK_HDR : PH_BODY;
      end
    end else if (!skip && phase_d == PH_BODY) begin
      if (kind_d == KIND_DATA) begin
        produce             = 1'b1;
        job_d.levels[9:0]   = {1'b1, data_byte_i, 1'b0};
        job_d.first         = SLOT_PRE;
        job_d.idx_end       = 5'd9;
        job_d.ms_a          = 16'd1;
      end else if (kind_d == KIND_TONE || kind_d == KIND_GAP) begin
        if (bidx_d == 3'd0) begin
          dshift_d = data_byte_i;
        end else if (bidx_d == 3'd1) begin
          produce         = (ms_w != 16'd0);
          job_d.levels[0] = (kind_d == KIND_TONE);
          job_d.first     = SLOT_PRE;
          job_d.idx_end   = SLOT_PRE;
          job_d.ms_a      = ms_w;
        end
      end else if (kind_d == KIND_DUMMY) begin
        if (bidx_d == 3'd0 || bidx_d == 3'd2) begin
          dshift_d = data_byte_i;
        end else if (bidx_d == 3'd1) begin
          pre_d = ms_w;
        end else if (bidx_d == 3'd3) begin
          produce       = 1'b1;
          job_d.levels  = {1'b1, 1'b1, DUMMY_BYTE, 1'b0, 1'b1, DUMMY_BYTE, 1'b0, 1'b1};
          job_d.first   = (pre_d != 16'd0) ? SLOT_PRE : 5'd1;
          job_d.idx_end = (ms_w != 16'd0) ? SLOT_POST : 5'd20;
          job_d.ms_a    = pre_d;
          job_d.ms_b    = ms_w;
        end
      end
      if (bidx_d != 3'd4) begin
        bidx_d = bidx_d + 3'd1;
      end
      rem_d = rem_d - 32'd1;
      if (rem_d == 32'd0) begin
        phase_d = PH_CHUNK_HDR;
        hcnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hcnt_q      <= '0;
      kind_q      <= '0;
      rem_q       <= '0;
      bidx_q      <= '0;
      dshift_q    <= '0;
      pre_q       <= '0;
      job_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        phase_q  <= phase_d;
        hcnt_q   <= hcnt_d;
        kind_q   <= kind_d;
        rem_q    <= rem_d;
        bidx_q   <= bidx_d;
        dshift_q <= dshift_d;
        pre_q    <= pre_d;
      end
      if (accept_i && produce) begin
        job_valid_q <= 1'b1;
      end else if (take_i) begin
        job_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && produce) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

`default_nettype wire

/* src/uefbs_emitter.sv */
`default_nettype none

module uefbs_emitter
  import uefbs_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  input  wire job_t            job_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 level_o,
  output logic [RUN_W-1:0]     run_length_o,
  output logic                 last_o
);

  logic                busy_q, busy_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [SLOT_W-1:0]   end_q;
  logic [SLOTS-1:0]    lv_q;
  logic [RUN_W-1:0]    len_a_q, len_b_q;
  logic                out_valid_q, out_valid_d;
  logic                level_q;
  logic [RUN_W-1:0]    run_q, run_d;
  logic                last_q;
  logic                adv;
  logic                at_end;
  logic [39:0]         prod_a, prod_b;

  assign adv    = !out_valid_q || !out_stall_i;
  assign at_end = (idx_q == end_q);
  assign take_o = job_valid_i && (!busy_q || (adv && at_end));

  assign prod_a = 40'(job_i.ms_a) * 40'(MS_RECIP);
  assign prod_b = 40'(job_i.ms_b) * 40'(MS_RECIP);

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (idx_q == SLOT_PRE) begin
      run_d = len_a_q;
    end else if (idx_q == SLOT_POST) begin
      run_d = len_b_q;
    end else begin
      run_d = RUN_W'(1);
    end
    if (adv) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        idx_d = idx_q + 5'd1;
        if (at_end) begin
          busy_d = 1'b0;
        end
      end
    end
    if (take_o) begin
      busy_d = 1'b1;
      idx_d  = job_i.first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (take_o) begin
      end_q   <= job_i.idx_end;
      lv_q    <= job_i.levels;
      len_a_q <= prod_a[39:MS_SHIFT];
      len_b_q <= prod_b[39:MS_SHIFT];
    end
    if (adv && busy_q) begin
      level_q <= lv_q[idx_q];
      run_q   <= run_d;
      last_q  <= at_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign level_o      = level_q;
  assign run_length_o = run_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

/* src/uef_tape_chunk_to_bitstream_core.sv */
// A byte's first run passes the parser job register, the sequencer index and the output register.
// Throughput: one run per cycle from the run sequencer while out_stall_i is low; a data byte
// gives ten runs, a tone or gap chunk's second body byte one, a dummy chunk's fourth body byte
// twenty to twenty-two. Other bytes give no run; input stalls while a job waits untaken.
// Reset: asynchronous, active low; returns the parser to header skip and empties all stages.
`default_nettype none

module uef_tape_chunk_to_bitstream_core
  import uefbs_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             file_start_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  level_o,
  output logic [RUN_W-1:0]      run_length_o,
  output logic                  last_o
);

  logic job_valid;
  job_t job;
  logic take;
  logic accept;

  assign in_stall_o = job_valid && !take;
  assign accept     = in_valid_i && !in_stall_o;

  uefbs_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .file_start_i(file_start_i),
    .take_i      (take),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  uefbs_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_o),
    .run_length_o(run_length_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
